// File: src/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, request and result types shared by the ALU modules.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int WORD_W = 32;

	typedef enum logic [3:0] {
		OP_ADD    = 4'd0,
		OP_SUB    = 4'd1,
		OP_MUL    = 4'd2,
		OP_DIV    = 4'd3,
		OP_GT     = 4'd4,
		OP_LT     = 4'd5,
		OP_GE     = 4'd6,
		OP_LE     = 4'd7,
		OP_EQ     = 4'd8,
		OP_NE     = 4'd9,
		OP_MIN    = 4'd10,
		OP_MAX    = 4'd11,
		OP_INC    = 4'd12,
		OP_DEC    = 4'd13,
		OP_TO_INT = 4'd14,
		OP_NONE   = 4'd15
	} op_t;

	typedef struct packed {
		logic [3:0]         operation;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} fpa_req_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               compare_true;
		logic               divide_by_zero;
	} fpa_res_t;

endpackage

// File: src/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step of an unsigned divide; passes its partial remainder,
// quotient and carried request to the next cell every cycle.
// ----------------------------------------------------------------------------
module fpa_div_cell
	import fpa_pkg::*;
#(
	parameter int DW = 40,
	parameter int RW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vin,
	input  logic [RW-1:0] rem_in,
	input  logic [DW-1:0] quo_in,
	input  logic [31:0]   dsr_in,
	input  logic          neg_in,
	input  logic [31:0]   a_in,
	input  logic          dz_in,
	output logic          vout,
	output logic [RW-1:0] rem_out,
	output logic [DW-1:0] quo_out,
	output logic [31:0]   dsr_out,
	output logic          neg_out,
	output logic [31:0]   a_out,
	output logic          dz_out
);

	logic [RW-1:0] trial;
	logic [RW:0]   diff;

	always_comb begin
		trial = {rem_in[RW-2:0], quo_in[DW-1]};
		diff  = {1'b0, trial} - {{(RW-31){1'b0}}, dsr_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (diff[RW]) begin
			rem_out <= trial;
		end else begin
			rem_out <= diff[RW-1:0];
		end
		quo_out <= {quo_in[DW-2:0], ~diff[RW]};
		dsr_out <= dsr_in;
		neg_out <= neg_in;
		a_out   <= a_in;
		dz_out  <= dz_in;
	end

endmodule

// File: src/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// Signed fixed-point ALU
// Add, subtract, multiply, divide, compares, min/max, inc/dec and to_int.
// ----------------------------------------------------------------------------
// A request is taken in every cycle (busy stays low). Every operation passes
// through the same stages, set by the divider: an input stage, a row of
// 32+FRACTION_BITS cells with one quotient bit per cell, and an output
// register. Results leave in request order, one strobe per request, and
// cannot be held off.
module fixed_point_q24_8_alu
	import fpa_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  fpa_req_t req,
	output logic     done,
	output fpa_res_t res
);

	localparam int DW = 32 + FRACTION_BITS;
	localparam int RW = 33;
	localparam int NC = DW;
	localparam int LAT = NC + 2;

	assign busy = 1'b0;

	// Stage 1: operand conditioning and all simple results.
	logic        v_s1;
	fpa_res_t    simple_s1;
	logic        is_mul_s1, is_div_s1;
	logic [DW-1:0] dvd_s1;
	logic [31:0] dsr_s1;
	logic        neg_s1;
	logic signed [31:0] a_s1, b_s1;

	fpa_res_t simple_c;
	logic signed [31:0] a, b, one_w, ti;
	logic [31:0] mag_a, mag_b;
	op_t op;

	always_comb begin
		op = op_t'(req.operation);
		a = req.operand_a;
		b = req.operand_b;
		one_w = 32'sd1 <<< FRACTION_BITS;
		mag_a = a[31] ? 32'(-a) : 32'(a);
		mag_b = b[31] ? 32'(-b) : 32'(b);
		ti = a >>> FRACTION_BITS;
		if (a[31] && (a[FRACTION_BITS-1:0] != '0)) ti = ti + 32'sd1;
		simple_c = '0;
		unique case (op)
			OP_ADD:    simple_c.result_value = a + b;
			OP_SUB:    simple_c.result_value = a - b;
			OP_GT:     simple_c.compare_true = a > b;
			OP_LT:     simple_c.compare_true = a < b;
			OP_GE:     simple_c.compare_true = a >= b;
			OP_LE:     simple_c.compare_true = a <= b;
			OP_EQ:     simple_c.compare_true = a == b;
			OP_NE:     simple_c.compare_true = a != b;
			OP_MIN:    simple_c.result_value = (a <= b) ? a : b;
			OP_MAX:    simple_c.result_value = (a >= b) ? a : b;
			OP_INC:    simple_c.result_value = a + one_w;
			OP_DEC:    simple_c.result_value = a - one_w;
			OP_TO_INT: simple_c.result_value = ti;
			OP_DIV: begin
				if (b == 32'sd0) begin
					simple_c.result_value   = a;
					simple_c.divide_by_zero = 1'b1;
				end
			end
			default: simple_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		simple_s1 <= simple_c;
		is_mul_s1 <= (op == OP_MUL);
		is_div_s1 <= (op == OP_DIV) && (b != 32'sd0);
		dvd_s1    <= {mag_a, {FRACTION_BITS{1'b0}}};
		dsr_s1    <= mag_b;
		neg_s1    <= a[31] ^ b[31];
		a_s1      <= a;
		b_s1      <= b;
	end

	// Multiply: one 32x32 product, registered, then shifted on the way out.
	logic signed [63:0] prod_s2;
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
	end

	// Divider chain; the simple result rides in the a_in slot.
	logic          cv   [NC+1];
	logic [RW-1:0] crem [NC+1];
	logic [DW-1:0] cquo [NC+1];
	logic [31:0]   cdsr [NC+1];
	logic          cneg [NC+1];
	logic [31:0]   caux [NC+1];
	logic          cdz  [NC+1];

	assign cv[0]   = v_s1;
	assign crem[0] = '0;
	assign cquo[0] = dvd_s1;
	assign cdsr[0] = dsr_s1;
	assign cneg[0] = neg_s1;
	assign caux[0] = simple_s1.result_value;
	assign cdz[0]  = simple_s1.compare_true;

	genvar gi;
	generate
		for (gi = 0; gi < NC; gi++) begin : g_cell
			fpa_div_cell #(.DW(DW), .RW(RW)) u_cell (
				.clk(clk), .arst_n(arst_n),
				.vin(cv[gi]), .rem_in(crem[gi]), .quo_in(cquo[gi]),
				.dsr_in(cdsr[gi]), .neg_in(cneg[gi]), .a_in(caux[gi]),
				.dz_in(cdz[gi]),
				.vout(cv[gi+1]), .rem_out(crem[gi+1]), .quo_out(cquo[gi+1]),
				.dsr_out(cdsr[gi+1]), .neg_out(cneg[gi+1]), .a_out(caux[gi+1]),
				.dz_out(cdz[gi+1])
			);
		end
	endgenerate

	// Side flags and the product travel in delay lines matching the chain.
	logic [NC-1:0] mul_d_q, div_d_q, dz_d_q;
	logic [31:0]   mres_q [NC-1];
	logic [31:0]   mul_now;

	assign mul_now = 32'(prod_s2 >>> FRACTION_BITS);

	always_ff @(posedge clk) begin
		mul_d_q <= {mul_d_q[NC-2:0], is_mul_s1};
		div_d_q <= {div_d_q[NC-2:0], is_div_s1};
		dz_d_q  <= {dz_d_q[NC-2:0], simple_s1.divide_by_zero};
		mres_q[0] <= mul_now;
		for (int i = 1; i < NC - 1; i++) mres_q[i] <= mres_q[i-1];
	end

	logic [DW-1:0] qmag;
	logic [31:0]   qres;
	fpa_res_t      out_c;

	always_comb begin
		qmag = cneg[NC] ? DW'(-cquo[NC]) : cquo[NC];
		qres = qmag[31:0];
		out_c = '0;
		out_c.divide_by_zero = dz_d_q[NC-1];
		out_c.compare_true   = cdz[NC];
		priority if (div_d_q[NC-1]) begin
			out_c.result_value = qres;
		end else if (mul_d_q[NC-1]) begin
			out_c.result_value = mres_q[NC-2];
		end else begin
			out_c.result_value = caux[NC];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cv[NC];
		end
	end

	always_ff @(posedge clk) begin
		res <= out_c;
	end

`ifndef SYNTHESIS
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start, LAT) && $past(arst_n, LAT) |-> done)
		else $error("result strobe missing");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(res.compare_true && res.divide_by_zero))
		else $error("compare and divide flags both set");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.divide_by_zero |-> res.compare_true == 1'b0)
		else $error("divide flag with compare flag");
`endif

endmodule

// File: verif/tb_fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed and random requests into the Q24.8 ALU, predicts each
// result in the bench, and compares the results in request order.
// ----------------------------------------------------------------------------
module tb_fixed_point_q24_8_alu;
	import fpa_pkg::*;

	localparam int FRAC       = 8;
	localparam int LATENCY    = FRAC + 34;
	localparam int N_RANDOM   = 2000;
	localparam int CYCLE_MAX  = 400000;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	fpa_req_t req;
	logic     done;
	fpa_res_t res;

	fpa_req_t pending_reqs[$];
	fpa_res_t expected_results[$];
	int       send_idle_pct;
	bit       hold_sender;
	int       mismatches;
	int       cycle_count;

	fixed_point_q24_8_alu #(.FRACTION_BITS(FRAC)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .res(res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic fpa_res_t alu_compute(fpa_req_t r);
		fpa_res_t       o;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] p;
		logic signed [63:0] one;
		a   = 64'(r.operand_a);
		b   = 64'(r.operand_b);
		one = 64'sd1 <<< FRAC;
		o   = '0;
		unique case (op_t'(r.operation))
			OP_ADD: o.result_value = 32'(a + b);
			OP_SUB: o.result_value = 32'(a - b);
			OP_MUL: begin
				p = a * b;
				o.result_value = 32'(p >>> FRAC);
			end
			OP_DIV: begin
				if (b == 0) begin
					o.result_value   = 32'(a);
					o.divide_by_zero = 1'b1;
				end else begin
					o.result_value = 32'((a * one) / b);
				end
			end
			OP_GT:     o.compare_true = a > b;
			OP_LT:     o.compare_true = a < b;
			OP_GE:     o.compare_true = a >= b;
			OP_LE:     o.compare_true = a <= b;
			OP_EQ:     o.compare_true = a == b;
			OP_NE:     o.compare_true = a != b;
			OP_MIN:    o.result_value = 32'((a <= b) ? a : b);
			OP_MAX:    o.result_value = 32'((a >= b) ? a : b);
			OP_INC:    o.result_value = 32'(a + one);
			OP_DEC:    o.result_value = 32'(a - one);
			OP_TO_INT: o.result_value = 32'(a / one);
			default:   o = '0;
		endcase
		return o;
	endfunction

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return $urandom_range(0, 4) << FRAC;
			3: return -($urandom_range(0, 4) << FRAC);
			4: return $urandom_range(0, 1) ? $urandom_range(0, 2000) : -$urandom_range(0, 2000);
			5: return 32'(int'($urandom_range(0, 65535)) - 32768) << FRAC;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_request(logic [3:0] op, logic [31:0] a, logic [31:0] b);
		fpa_req_t r;
		r.operation = op;
		r.operand_a = a;
		r.operand_b = b;
		pending_reqs.push_back(r);
	endtask

	// Driver: a request is taken at an edge with start high and busy low.
	// The head of the queue is the request currently on the ports.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req   <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(alu_compute(req));
				void'(pending_reqs.pop_front());
			end
			if (pending_reqs.size() > 0 && !hold_sender &&
			    $urandom_range(0, 99) >= send_idle_pct) begin
				start <= 1'b1;
				req   <= pending_reqs[0];
			end else if (!(start && busy)) begin
				start <= 1'b0;
				req   <= fpa_req_t'({4'($urandom), $urandom, $urandom});
			end
		end
	end

	// Monitor: every strobe must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", res);
			end else begin
				fpa_res_t e;
				e = expected_results.pop_front();
				if (e.result_value !== res.result_value ||
				    e.compare_true !== res.compare_true ||
				    e.divide_by_zero !== res.divide_by_zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %h cmp %b dz %b, got %h %b %b",
						         e.result_value, e.compare_true, e.divide_by_zero,
						         res.result_value, res.compare_true, res.divide_by_zero);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_MAX) begin
			$display("** fixed_point_q24_8_alu: FAILED **");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] corners[6];
		int          op_code;
		mismatches    = 0;
		cycle_count   = 0;
		send_idle_pct = 30;
		hold_sender   = 1'b0;
		arst_n        = 1'b0;
		corners = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
		repeat (10) @(posedge clk);
		arst_n = 1'b1;

		// Directed: every code incl. the unused one, extremes, divide by zero.
		for (int op = 0; op < 16; op++)
			queue_request(op[3:0], corners[op % 6], corners[(op + 1) % 6]);
		queue_request(OP_DIV, 32'h7fff_ffff, 32'h0);
		queue_request(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		queue_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
		queue_request(OP_ADD, 32'h7fff_ffff, 32'h1);
		queue_request(OP_TO_INT, 32'hffff_ff01, 32'h0);
		queue_request(OP_EQ, 32'h1234_5678, 32'h1234_5678);
		queue_request(OP_MUL, 32'hffff_ffff, 32'h1);
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				wait_drained();
				send_idle_pct = 73;
			end else if (i == 2 * N_RANDOM / 3) begin
				wait_drained();
				send_idle_pct = 0;
			end
			op_code = $urandom_range(0, 15);
			queue_request(op_code[3:0], pick_operand(),
			              ($urandom_range(0, 19) == 0) ? 32'h0 : pick_operand());
		end
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("** fixed_point_q24_8_alu: PASSED **");
		else
			$display("** fixed_point_q24_8_alu: FAILED **");
		$finish;
	end
endmodule
